[rtl/assert_macros.svh]
// assertion macros shared by the supervisor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define SDBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdbs implication check failed");

// invariant checked at every rising edge outside reset
`define SDBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sdbs invariant check failed");

`endif

[rtl/sdbs_pkg.sv]
// types and constants of the servo drive bring-up supervisor
package sdbs_pkg;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_MODE      = 2'd1,
        OP_CMD       = 2'd2,
        OP_ALARM_RST = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_STATUS = 2'd0,
        ACT_READ   = 2'd1,
        ACT_WRITE  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_INIT   = 4'd1,
        ST_CHECK  = 4'd2,
        ST_RESET  = 4'd3,
        ST_ENABLE = 4'd4,
        ST_PARAM  = 4'd5,
        ST_RUN    = 4'd6,
        ST_STOP   = 4'd7,
        ST_FAULT  = 4'd8
    } t_state;

    typedef enum logic [2:0] {
        CFG_ENABLE_ADDR      = 3'd0,
        CFG_SPEED_ADDR       = 3'd1,
        CFG_FWD_TORQUE_ADDR  = 3'd2,
        CFG_REV_TORQUE_ADDR  = 3'd3,
        CFG_SPEED_LIMIT_ADDR = 3'd4,
        CFG_SPEED_LIMIT_VAL  = 3'd5,
        CFG_MONITOR_PERIOD   = 3'd6,
        CFG_DEADBAND         = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] enable_reg_addr;
        logic [15:0] speed_reg_addr;
        logic [15:0] fwd_torque_reg_addr;
        logic [15:0] rev_torque_reg_addr;
        logic [15:0] speed_limit_reg_addr;
        logic [15:0] speed_limit_value;
        logic [15:0] monitor_period_ms;
        logic [15:0] command_deadband;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [31:0]        now_ms;
        logic               reply_ready;
        logic [15:0]        reply_value;
        logic [7:0]         mode_value;
        logic signed [15:0] command_value;
    } t_in_item;

    typedef struct packed {
        t_action     kind;
        logic [15:0] addr;
        logic [15:0] data;
    } t_act;

    localparam int MAX_ACTS = 5;
    localparam int CNT_W    = 3;

    // one classified request: its bus actions in order and the final state
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        t_act [MAX_ACTS-1:0]   acts;
        t_state                fsm;
    } t_job;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [15:0] LINK_LOST         = 16'hFFFF;
    localparam logic [31:0] INIT_RETRY_MS     = 32'd5000;
    localparam logic [31:0] ALARM_RESET_MS    = 32'd500;
    localparam logic [31:0] ENABLE_TIMEOUT_MS = 32'd2000;
    localparam logic [15:0] ALARM_CLR_ADDR    = 16'h2000;
    localparam logic [15:0] ALARM_CLR_DATA    = 16'd2;
    localparam logic [15:0] ENABLE_ON         = 16'd1;
    localparam logic [15:0] ENABLE_OFF        = 16'd0;
    localparam logic [7:0]  MODE_SPEED        = 8'd1;
    localparam logic [7:0]  MODE_TORQUE       = 8'd2;

    localparam logic [15:0]        SPEED_LIMIT_RESET = 16'd500;
    localparam logic [15:0]        PERIOD_RESET      = 16'd100;
    localparam logic [15:0]        DEADBAND_RESET    = 16'd2;
    localparam logic signed [15:0] LAST_SENT_RESET   = -16'sd9999;

    // monitored drive registers, polled from entry 0 (listed last); entry 7 is a dummy slot
    localparam logic [7:0][15:0] MON_ADDR = {
        16'h0000, 16'h1012, 16'h1008, 16'h1007,
        16'h1000, 16'h1009, 16'h1013, 16'h2001
    };

endpackage

[rtl/sdbs_in_if.sv]
// request channel into the supervisor
interface sdbs_in_if ();
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic               reply_ready;
    logic [15:0]        reply_value;
    logic [7:0]         mode_value;
    logic signed [15:0] command_value;

    modport source (
        output valid, op, now_ms, reply_ready, reply_value, mode_value, command_value,
        input  ready
    );
    modport sink (
        input  valid, op, now_ms, reply_ready, reply_value, mode_value, command_value,
        output ready
    );
endinterface

[rtl/sdbs_out_if.sv]
// result channel out of the supervisor
interface sdbs_out_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] reg_addr;
    logic [15:0] reg_data;
    logic [3:0]  fsm_code;
    logic        last;

    modport source (
        output valid, action, reg_addr, reg_data, fsm_code, last,
        input  ready
    );
    modport sink (
        input  valid, action, reg_addr, reg_data, fsm_code, last,
        output ready
    );
endinterface

[rtl/sdbs_front.sv]
// front end: supervisor state, monitor and bring-up machine, builds one job per request
`include "assert_macros.svh"

module sdbs_front import sdbs_pkg::*; #(
    parameter int MONITOR_REGS = 7
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_take,
    input  t_in_item i_item,
    output t_job     o_job
);

    localparam int IW = (MONITOR_REGS > 1) ? $clog2(MONITOR_REGS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(MONITOR_REGS - 1);

    t_state             r_state,     n_state;
    logic [31:0]        r_entry,     n_entry;
    logic [31:0]        r_last_mon,  n_last_mon;
    logic [IW-1:0]      r_mon_idx,   n_mon_idx;
    logic               r_read_out,  n_read_out;
    logic [15:0]        r_status,    n_status;
    logic [15:0]        r_alarm,     n_alarm;
    logic [7:0]         r_tmode,     n_tmode;
    logic signed [15:0] r_tcmd,      n_tcmd;
    logic signed [15:0] r_last_sent, n_last_sent;

    // values after the monitor, seen by the machine
    t_state        m_state;
    logic [31:0]   m_entry;
    logic [IW-1:0] m_idx;
    logic          m_read_out;
    logic [15:0]   m_status;
    logic [15:0]   m_alarm;
    logic          mon_due;
    logic          mon_emit;
    logic [31:0]   elapsed;

    logic signed [16:0] diff;
    logic [16:0]        abs_diff;
    logic               resend;
    logic [15:0]        mag;

    t_act [3:0]       ma;
    logic [CNT_W-1:0] mcnt;
    logic [CNT_W-1:0] total;

    function automatic t_act mk_act(t_action kind, logic [15:0] addr, logic [15:0] data);
        t_act a;
        a.kind = kind;
        a.addr = addr;
        a.data = data;
        return a;
    endfunction

    assign elapsed = i_item.now_ms - r_entry;
    assign mon_due = (i_item.op == OP_TICK) &&
                     ((i_item.now_ms - r_last_mon) > {16'd0, i_cfg.monitor_period_ms});

    assign diff     = {r_tcmd[15], r_tcmd} - {r_last_sent[15], r_last_sent};
    assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
    assign resend   = abs_diff >= {1'b0, i_cfg.command_deadband};
    assign mag      = r_tcmd[15] ? 16'(~r_tcmd + 16'sd1) : 16'(r_tcmd);

    // round-robin monitor: collect the pending reply or request the next register
    always_comb begin
        m_state    = r_state;
        m_entry    = r_entry;
        m_idx      = r_mon_idx;
        m_read_out = r_read_out;
        m_status   = r_status;
        m_alarm    = r_alarm;
        mon_emit   = 1'b0;
        if (mon_due) begin
            if (r_read_out) begin
                if (i_item.reply_ready) begin
                    m_read_out = 1'b0;
                    if (r_mon_idx == '0) begin
                        m_status = i_item.reply_value;
                    end else if (r_mon_idx == IW'(1)) begin
                        m_alarm = i_item.reply_value;
                    end
                    if (r_mon_idx == '0 && i_item.reply_value == LINK_LOST) begin
                        if (r_state != ST_INIT && r_state != ST_IDLE) begin
                            m_state = ST_INIT;
                            m_entry = i_item.now_ms;
                        end
                        m_idx = '0;
                    end else if (r_mon_idx == IDX_LAST) begin
                        m_idx = '0;
                    end else begin
                        m_idx = r_mon_idx + IW'(1);
                    end
                end
            end else begin
                mon_emit   = 1'b1;
                m_read_out = 1'b1;
            end
        end
    end

    // next state of the bring-up machine and of the event handling
    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_last_mon  = r_last_mon;
        n_mon_idx   = r_mon_idx;
        n_read_out  = r_read_out;
        n_status    = r_status;
        n_alarm     = r_alarm;
        n_tmode     = r_tmode;
        n_tcmd      = r_tcmd;
        n_last_sent = r_last_sent;
        unique case (i_item.op)
            OP_TICK: begin
                n_state    = m_state;
                n_entry    = m_entry;
                n_mon_idx  = m_idx;
                n_read_out = m_read_out;
                n_status   = m_status;
                n_alarm    = m_alarm;
                if (mon_due) begin
                    n_last_mon = i_item.now_ms;
                end
                unique case (m_state)
                    ST_IDLE: begin
                        n_state = ST_INIT;
                        n_entry = i_item.now_ms;
                    end
                    ST_INIT: begin
                        if (m_status != LINK_LOST) begin
                            n_state = ST_CHECK;
                            n_entry = i_item.now_ms;
                        end else if (elapsed > INIT_RETRY_MS) begin
                            n_entry = i_item.now_ms;
                        end
                    end
                    ST_CHECK: begin
                        n_state = (m_alarm == 16'd0) ? ST_ENABLE : ST_RESET;
                        n_entry = i_item.now_ms;
                    end
                    ST_RESET: begin
                        if (elapsed >= ALARM_RESET_MS) begin
                            n_state = ST_CHECK;
                            n_entry = i_item.now_ms;
                        end
                    end
                    ST_ENABLE: begin
                        if (m_status[0]) begin
                            n_state = ST_PARAM;
                            n_entry = i_item.now_ms;
                        end else if (elapsed > ENABLE_TIMEOUT_MS) begin
                            n_state = ST_FAULT;
                        end
                    end
                    ST_PARAM: begin
                        n_state = ST_RUN;
                        n_entry = i_item.now_ms;
                    end
                    ST_RUN: begin
                        if (m_alarm != 16'd0) begin
                            n_state = ST_FAULT;
                        end else if (resend) begin
                            n_last_sent = r_tcmd;
                        end
                    end
                    ST_STOP: begin
                        n_state = ST_IDLE;
                        n_entry = i_item.now_ms;
                    end
                    default: begin
                    end
                endcase
            end
            OP_MODE: begin
                if (r_tmode != i_item.mode_value) begin
                    n_tmode = i_item.mode_value;
                    if (r_state == ST_RUN) begin
                        n_state = ST_STOP;
                    end
                end
            end
            OP_CMD: begin
                n_tcmd = i_item.command_value;
            end
            OP_ALARM_RST: begin
                if (r_state == ST_FAULT || r_state == ST_CHECK) begin
                    n_state = ST_RESET;
                    n_entry = i_item.now_ms;
                end
            end
        endcase
    end

    // bus writes of the machine
    always_comb begin
        ma   = '0;
        mcnt = '0;
        if (i_item.op == OP_TICK) begin
            unique case (m_state)
                ST_RESET: begin
                    if (elapsed < ALARM_RESET_MS) begin
                        ma[0] = mk_act(ACT_WRITE, ALARM_CLR_ADDR, ALARM_CLR_DATA);
                        mcnt  = CNT_W'(1);
                    end
                end
                ST_ENABLE: begin
                    ma[0] = mk_act(ACT_WRITE, i_cfg.enable_reg_addr, ENABLE_ON);
                    mcnt  = CNT_W'(1);
                end
                ST_PARAM: begin
                    ma[0] = mk_act(ACT_WRITE, i_cfg.speed_limit_reg_addr,
                                   i_cfg.speed_limit_value);
                    mcnt  = CNT_W'(1);
                end
                ST_RUN: begin
                    if (m_alarm == 16'd0 && resend) begin
                        if (r_tmode == MODE_SPEED) begin
                            ma[0] = mk_act(ACT_WRITE, i_cfg.speed_reg_addr, mag);
                            mcnt  = CNT_W'(1);
                        end else if (r_tmode == MODE_TORQUE) begin
                            ma[0] = mk_act(ACT_WRITE, i_cfg.fwd_torque_reg_addr, mag);
                            ma[1] = mk_act(ACT_WRITE, i_cfg.rev_torque_reg_addr, mag);
                            mcnt  = CNT_W'(2);
                        end
                    end
                end
                ST_STOP: begin
                    ma[0] = mk_act(ACT_WRITE, i_cfg.speed_reg_addr, 16'd0);
                    ma[1] = mk_act(ACT_WRITE, i_cfg.fwd_torque_reg_addr, 16'd0);
                    ma[2] = mk_act(ACT_WRITE, i_cfg.rev_torque_reg_addr, 16'd0);
                    ma[3] = mk_act(ACT_WRITE, i_cfg.enable_reg_addr, ENABLE_OFF);
                    mcnt  = CNT_W'(4);
                end
                default: begin
                end
            endcase
        end
    end

    // job: monitor read first, then machine writes, or one status result
    assign total = mcnt + CNT_W'(mon_emit);

    always_comb begin
        o_job     = '0;
        o_job.fsm = n_state;
        if (total == '0) begin
            o_job.cnt     = CNT_W'(1);
            o_job.acts[0] = mk_act(ACT_STATUS, 16'd0, 16'd0);
        end else begin
            o_job.cnt = total;
            if (mon_emit) begin
                o_job.acts[0] = mk_act(ACT_READ, MON_ADDR[3'(r_mon_idx)], 16'd0);
                o_job.acts[1] = ma[0];
                o_job.acts[2] = ma[1];
                o_job.acts[3] = ma[2];
                o_job.acts[4] = ma[3];
            end else begin
                o_job.acts[0] = ma[0];
                o_job.acts[1] = ma[1];
                o_job.acts[2] = ma[2];
                o_job.acts[3] = ma[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry     <= '0;
            r_last_mon  <= '0;
            r_mon_idx   <= '0;
            r_read_out  <= 1'b0;
            r_status    <= LINK_LOST;
            r_alarm     <= '0;
            r_tmode     <= MODE_SPEED;
            r_tcmd      <= '0;
            r_last_sent <= LAST_SENT_RESET;
        end else if (i_take) begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_last_mon  <= n_last_mon;
            r_mon_idx   <= n_mon_idx;
            r_read_out  <= n_read_out;
            r_status    <= n_status;
            r_alarm     <= n_alarm;
            r_tmode     <= n_tmode;
            r_tcmd      <= n_tcmd;
            r_last_sent <= n_last_sent;
        end
    end

    `SDBS_ASSERT_IMP(a_job_cnt, i_clk, i_rst_n, i_take, o_job.cnt != '0 && o_job.cnt <= CNT_W'(MAX_ACTS))

endmodule

[rtl/sdbs_queue.sv]
// two-entry job queue between front and back
`include "assert_macros.svh"

module sdbs_queue import sdbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr,    n_wr;
    logic [Q_PTR_W-1:0] r_rd,    n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));

    always_comb begin
        n_wr    = i_push ? r_wr + Q_PTR_W'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + Q_PTR_W'(1) : r_rd;
        n_count = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `SDBS_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, !o_empty)
    `SDBS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH))

endmodule

[rtl/sdbs_back.sv]
// back end: steps through the head job and drives the result register
`include "assert_macros.svh"

module sdbs_back import sdbs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  logic      i_empty,
    output logic      o_pop,
    sdbs_out_if.source o_out
);

    logic             r_valid, n_valid;
    logic [CNT_W-1:0] r_pos,   n_pos;
    t_action          r_action;
    logic [15:0]      r_addr;
    logic [15:0]      r_data;
    t_state           r_fsm;
    logic             r_last;

    logic load;
    logic is_last;
    t_act cur;

    assign load    = !i_empty && (!r_valid || o_out.ready);
    assign cur     = i_head.acts[r_pos];
    assign is_last = (r_pos == i_head.cnt - CNT_W'(1));
    assign o_pop   = load && is_last;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (load) begin
            n_valid = 1'b1;
            n_pos   = is_last ? '0 : r_pos + CNT_W'(1);
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_action <= cur.kind;
            r_addr   <= cur.addr;
            r_data   <= cur.data;
            r_fsm    <= i_head.fsm;
            r_last   <= is_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.action   = r_action;
    assign o_out.reg_addr = r_addr;
    assign o_out.reg_data = r_data;
    assign o_out.fsm_code = r_fsm;
    assign o_out.last     = r_last;

    // a partly sent job stays at the queue head
    `SDBS_ASSERT_IMP(a_partial_job_held, i_clk, i_rst_n, r_pos != '0, !i_empty)

endmodule

[rtl/servo_drive_bringup_supervisor_unit.sv]
// top level of the servo drive bring-up supervisor
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        op, now_ms, reply_ready, reply_value,
//                                    mode_value, command_value
//  o_out     out  valid/ready        action, reg_addr, reg_data, fsm_code, last
//  i_cfg_*   in   write enable only  i_cfg_idx selects, i_cfg_data written
//
//  a request is decoded and the supervisor state updated in the cycle it is taken;
//  its job enters a two-entry queue and comes out as 1 to 5 results, one per cycle while o_out is ready
//  the first result of a request passes through the job queue and then the result register
//  i_in.ready drops only while the job queue is full
//  synchronous active-low reset; no clearing pass, the block is ready the cycle after

module servo_drive_bringup_supervisor_unit import sdbs_pkg::*; #(
    parameter int MONITOR_REGS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdbs_in_if.sink     i_in,
    sdbs_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg     r_cfg, n_cfg;
    t_in_item item;
    t_job     job;
    t_job     head;
    logic     take;
    logic     q_empty;
    logic     q_full;
    logic     pop;

    // configuration registers; the user writes them only while the block is idle, the block does not enforce it
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE_ADDR:      n_cfg.enable_reg_addr      = i_cfg_data;
                CFG_SPEED_ADDR:       n_cfg.speed_reg_addr       = i_cfg_data;
                CFG_FWD_TORQUE_ADDR:  n_cfg.fwd_torque_reg_addr  = i_cfg_data;
                CFG_REV_TORQUE_ADDR:  n_cfg.rev_torque_reg_addr  = i_cfg_data;
                CFG_SPEED_LIMIT_ADDR: n_cfg.speed_limit_reg_addr = i_cfg_data;
                CFG_SPEED_LIMIT_VAL:  n_cfg.speed_limit_value    = i_cfg_data;
                CFG_MONITOR_PERIOD:   n_cfg.monitor_period_ms    = i_cfg_data;
                CFG_DEADBAND:         n_cfg.command_deadband     = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_reg_addr      <= '0;
            r_cfg.speed_reg_addr       <= '0;
            r_cfg.fwd_torque_reg_addr  <= '0;
            r_cfg.rev_torque_reg_addr  <= '0;
            r_cfg.speed_limit_reg_addr <= '0;
            r_cfg.speed_limit_value    <= SPEED_LIMIT_RESET;
            r_cfg.monitor_period_ms    <= PERIOD_RESET;
            r_cfg.command_deadband     <= DEADBAND_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // request intake: taken whenever the queue has room
    assign i_in.ready = !q_full;
    assign take       = i_in.valid && !q_full;

    assign item.op            = t_op'(i_in.op);
    assign item.now_ms        = i_in.now_ms;
    assign item.reply_ready   = i_in.reply_ready;
    assign item.reply_value   = i_in.reply_value;
    assign item.mode_value    = i_in.mode_value;
    assign item.command_value = i_in.command_value;

    // front: monitor and bring-up machine, one job per request
    sdbs_front #(
        .MONITOR_REGS (MONITOR_REGS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_item  (item),
        .o_job   (job)
    );

    // decouples intake from a stalled result port
    sdbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: one result per cycle from the head job while the result port is ready
    sdbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[bench/tb_servo_drive_bringup_supervisor_unit.sv]
// self-checking bench for the servo drive bring-up supervisor: stimulus, prediction, checks
module tb_servo_drive_bringup_supervisor_unit import sdbs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // drive-side constants of the bring-up sequence, kept apart from the rtl package
    localparam logic [15:0]        LOST_LINK    = 16'hFFFF;
    localparam logic [31:0]        INIT_RETRY   = 32'd5000;
    localparam logic [31:0]        CLEAR_WINDOW = 32'd500;
    localparam logic [31:0]        ENABLE_LIMIT = 32'd2000;
    localparam logic [15:0]        CLEAR_REG    = 16'h2000;
    localparam logic [15:0]        CLEAR_CODE   = 16'd2;
    localparam logic [7:0]         SPEED_MODE   = 8'd1;
    localparam logic [7:0]         TORQUE_MODE  = 8'd2;
    localparam logic signed [15:0] SENT_START   = -16'sd9999;
    localparam int                 POLL_REGS    = 7;
    localparam int                 MAX_OPS      = 5;

    // registers polled round robin, status first and alarm second
    localparam logic [15:0] POLL_ADDR [8] = '{
        16'h2001, 16'h1013, 16'h1009, 16'h1000, 16'h1007, 16'h1008, 16'h1012, 16'h0000
    };

    typedef logic [7:0][15:0] t_regs;

    typedef struct packed {
        t_op                op;
        logic [31:0]        now;
        logic               ready;
        logic [15:0]        reply;
        logic [7:0]         mode;
        logic signed [15:0] cmd;
    } t_req;

    // one bus operation as it should leave the result port
    typedef struct packed {
        t_action     kind;
        logic [15:0] addr;
        logic [15:0] data;
        t_state      fsm;
        logic        last;
    } t_busop;

    typedef struct packed {
        logic [2:0]           n;
        t_busop [MAX_OPS-1:0] op;
    } t_step;

    // supervisor state as seen from the bus
    typedef struct packed {
        t_state             fsm;
        logic [31:0]        entered;
        logic [31:0]        polled;
        logic [2:0]         poll_idx;
        logic               poll_busy;
        logic [15:0]        status;
        logic [15:0]        alarm;
        logic [7:0]         mode;
        logic signed [15:0] cmd;
        logic signed [15:0] sent;
    } t_sup;

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    sdbs_in_if  in_if ();
    sdbs_out_if out_if ();

    servo_drive_bringup_supervisor_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // model follows accepted requests; look runs ahead while stimulus is built
    t_sup   model;
    t_sup   look;
    t_regs  regs;
    t_req   in_flight;
    t_step  outcome;
    t_busop got;
    t_busop want;
    t_req   pending [$];
    t_busop ops_due [$];
    logic [31:0] look_now = '0;
    logic [8:0]  seen = '0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  in_steady = 0;
    bit  out_steady = 0;
    int  errors = 0;
    int  sent_n = 0;
    int  checked_n = 0;
    int  settings_n = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_sup sup_reset();
        t_sup s;
        s = '0;
        s.fsm    = ST_IDLE;
        s.status = LOST_LINK;
        s.mode   = SPEED_MODE;
        s.sent   = SENT_START;
        return s;
    endfunction

    function automatic t_regs setting(input logic [15:0] en, sp, fw, rv, la, lv, per, db);
        t_regs r;
        r[CFG_ENABLE_ADDR]      = en;
        r[CFG_SPEED_ADDR]       = sp;
        r[CFG_FWD_TORQUE_ADDR]  = fw;
        r[CFG_REV_TORQUE_ADDR]  = rv;
        r[CFG_SPEED_LIMIT_ADDR] = la;
        r[CFG_SPEED_LIMIT_VAL]  = lv;
        r[CFG_MONITOR_PERIOD]   = per;
        r[CFG_DEADBAND]         = db;
        return r;
    endfunction

    function automatic void add_op(inout t_step st, input t_action k,
                                   input logic [15:0] a, input logic [15:0] d);
        if (st.n < MAX_OPS) begin
            st.op[st.n] = '{kind: k, addr: a, data: d, fsm: ST_IDLE, last: 1'b0};
            st.n++;
        end
    endfunction

    // bus operations caused by one request, in issue order
    function automatic t_step supervise(inout t_sup s, input t_regs c, input t_req r);
        t_step       st;
        logic [31:0] elapsed;
        logic [2:0]  idx;
        int          d;
        logic [15:0] mag;
        st = '0;
        case (r.op)
            OP_TICK: begin
                // machine timeouts use the entry time from before the poll
                elapsed = r.now - s.entered;
                if (r.now - s.polled > {16'h0, c[CFG_MONITOR_PERIOD]}) begin
                    idx = s.poll_idx;
                    if (!s.poll_busy) begin
                        add_op(st, ACT_READ, POLL_ADDR[idx], 16'h0);
                        s.poll_busy = 1'b1;
                    end else if (r.ready) begin
                        // only status and alarm replies are kept
                        s.poll_busy = 1'b0;
                        if (idx == 3'd0) s.status = r.reply;
                        else if (idx == 3'd1) s.alarm = r.reply;
                        if (idx == 3'd0 && r.reply == LOST_LINK) begin
                            if (s.fsm != ST_INIT && s.fsm != ST_IDLE) begin
                                s.fsm = ST_INIT;
                                s.entered = r.now;
                            end
                            s.poll_idx = 3'd0;
                        end else begin
                            s.poll_idx = 3'((idx + 1) % POLL_REGS);
                        end
                    end
                    s.polled = r.now;
                end
                case (s.fsm)
                    ST_IDLE: begin
                        s.fsm = ST_INIT;
                        s.entered = r.now;
                    end
                    ST_INIT: begin
                        if (s.status != LOST_LINK) begin
                            s.fsm = ST_CHECK;
                            s.entered = r.now;
                        end else if (elapsed > INIT_RETRY) begin
                            s.entered = r.now;
                        end
                    end
                    ST_CHECK: begin
                        if (s.alarm == 16'h0) s.fsm = ST_ENABLE;
                        else s.fsm = ST_RESET;
                        s.entered = r.now;
                    end
                    ST_RESET: begin
                        if (elapsed < CLEAR_WINDOW) begin
                            add_op(st, ACT_WRITE, CLEAR_REG, CLEAR_CODE);
                        end else begin
                            s.fsm = ST_CHECK;
                            s.entered = r.now;
                        end
                    end
                    ST_ENABLE: begin
                        add_op(st, ACT_WRITE, c[CFG_ENABLE_ADDR], 16'd1);
                        if (s.status[0]) begin
                            s.fsm = ST_PARAM;
                            s.entered = r.now;
                        end else if (elapsed > ENABLE_LIMIT) begin
                            s.fsm = ST_FAULT;
                        end
                    end
                    ST_PARAM: begin
                        add_op(st, ACT_WRITE, c[CFG_SPEED_LIMIT_ADDR], c[CFG_SPEED_LIMIT_VAL]);
                        s.fsm = ST_RUN;
                        s.entered = r.now;
                    end
                    ST_RUN: begin
                        if (s.alarm != 16'h0) begin
                            s.fsm = ST_FAULT;
                        end else begin
                            d = int'(s.cmd) - int'(s.sent);
                            if (d < 0) d = -d;
                            if (d >= int'(c[CFG_DEADBAND])) begin
                                // magnitude in 16 bits, so the most negative command gives 0x8000
                                mag = (s.cmd < 0) ? 16'(-s.cmd) : s.cmd;
                                if (s.mode == SPEED_MODE) begin
                                    add_op(st, ACT_WRITE, c[CFG_SPEED_ADDR], mag);
                                end else if (s.mode == TORQUE_MODE) begin
                                    add_op(st, ACT_WRITE, c[CFG_FWD_TORQUE_ADDR], mag);
                                    add_op(st, ACT_WRITE, c[CFG_REV_TORQUE_ADDR], mag);
                                end
                                s.sent = s.cmd;
                            end
                        end
                    end
                    ST_STOP: begin
                        add_op(st, ACT_WRITE, c[CFG_SPEED_ADDR], 16'h0);
                        add_op(st, ACT_WRITE, c[CFG_FWD_TORQUE_ADDR], 16'h0);
                        add_op(st, ACT_WRITE, c[CFG_REV_TORQUE_ADDR], 16'h0);
                        add_op(st, ACT_WRITE, c[CFG_ENABLE_ADDR], 16'h0);
                        s.fsm = ST_IDLE;
                        s.entered = r.now;
                    end
                    default: begin
                    end
                endcase
            end
            OP_MODE: begin
                if (s.mode != r.mode) begin
                    s.mode = r.mode;
                    if (s.fsm == ST_RUN) s.fsm = ST_STOP;
                end
            end
            OP_CMD: begin
                s.cmd = r.cmd;
            end
            default: begin
                if (s.fsm == ST_FAULT || s.fsm == ST_CHECK) begin
                    s.fsm = ST_RESET;
                    s.entered = r.now;
                end
            end
        endcase
        if (st.n == 0) add_op(st, ACT_STATUS, 16'h0, 16'h0);
        for (int k = 0; k < st.n; k++) begin
            st.op[k].fsm  = s.fsm;
            st.op[k].last = (k == st.n - 1);
        end
        return st;
    endfunction

    // per-request wait, with occasional stretches of back-to-back traffic
    function automatic int pick_wait(inout bit steady);
        if ($urandom_range(0, 15) == 0) steady = !steady;
        return steady ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic string show(input t_busop o);
        return $sformatf("action %0d addr %h data %h state %0d last %0d",
                         o.kind, o.addr, o.data, o.fsm, o.last);
    endfunction

    task automatic note_fault(input string why, input t_busop exp_op, input t_busop act_op);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s: expected %s, got %s", $realtime, why, show(exp_op), show(act_op));
        end
    endtask

    // request driver: the prediction is taken at the edge that accepts the request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                outcome = supervise(model, regs, in_flight);
                for (int k = 0; k < outcome.n; k++) ops_due.push_back(outcome.op[k]);
                seen[model.fsm] = 1'b1;
                sent_n++;
                in_gap = pick_wait(in_steady);
            end
            // the port is free unless a request is still held against a low ready
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_flight = pending.pop_front();
                    in_if.op            <= in_flight.op;
                    in_if.now_ms        <= in_flight.now;
                    in_if.reply_ready   <= in_flight.ready;
                    in_if.reply_value   <= in_flight.reply;
                    in_if.mode_value    <= in_flight.mode;
                    in_if.command_value <= in_flight.cmd;
                    in_if.valid         <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{kind: t_action'(out_if.action), addr: out_if.reg_addr,
                        data: out_if.reg_data, fsm: t_state'(out_if.fsm_code),
                        last: out_if.last};
                if (ops_due.size() == 0) begin
                    note_fault("result with nothing outstanding", '0, got);
                end else begin
                    want = ops_due.pop_front();
                    if (got !== want) note_fault("result differs", want, got);
                end
                checked_n++;
                out_gap = pick_wait(out_steady);
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // queue one request and keep the look-ahead copy in step with it
    task automatic add_req(input t_op op, input logic [31:0] now, input logic ready,
                           input logic [15:0] reply, input logic [7:0] mode,
                           input logic [15:0] cmd);
        t_req  r;
        t_step scratch;
        r = '{op: op, now: now, ready: ready, reply: reply, mode: mode, cmd: cmd};
        scratch = supervise(look, regs, r);
        if (op == OP_TICK) look_now = now;
        pending.push_back(r);
    endtask

    // mostly well-formed bring-up traffic with random content, some noise
    task automatic add_random(input int n);
        int          roll;
        int          p;
        int          q;
        logic [31:0] per;
        t_op         op;
        logic [31:0] now;
        logic [15:0] reply;
        logic [7:0]  mode;
        logic [15:0] cmd;
        per = {16'h0, regs[CFG_MONITOR_PERIOD]};
        for (int k = 0; k < n; k++) begin
            roll  = $urandom_range(0, 99);
            p     = $urandom_range(0, 99);
            now   = look_now;
            reply = 16'($urandom);
            mode  = 8'($urandom);
            cmd   = 16'($urandom);
            if (roll < 4) begin
                // noise: any field, any time stamp
                op  = t_op'($urandom_range(0, 3));
                now = $urandom;
            end else begin
                if ((look.fsm == ST_FAULT || look.fsm == ST_CHECK) && p < 30) op = OP_ALARM_RST;
                else if (look.fsm == ST_RUN && p < 25) op = OP_CMD;
                else if (look.fsm == ST_RUN && p < 37) op = OP_MODE;
                else if (p < 6) op = OP_CMD;
                else if (p < 9) op = OP_MODE;
                else if (p < 11) op = OP_ALARM_RST;
                else op = OP_TICK;

                if (op == OP_TICK) begin
                    // time steps: mostly one poll per tick, some short, some past timeouts
                    q = $urandom_range(0, 99);
                    if (q < 70) now = look_now + per + 32'd1 + $urandom_range(0, 40);
                    else if (q < 85) now = look_now + $urandom_range(0, per);
                    else if (q < 95) now = look_now + $urandom_range(300, 2600);
                    else now = look_now + $urandom_range(4000, 7000);
                    // replies shaped by which register the poll is waiting on
                    q = $urandom_range(0, 99);
                    if (look.poll_busy && look.poll_idx == 3'd0) begin
                        if (q < 75) begin
                            reply = 16'($urandom) | 16'h0001;
                            if (reply == LOST_LINK) reply = 16'h8001;
                        end else if (q < 88) begin
                            reply = 16'($urandom) & 16'hFFFE;
                        end else begin
                            reply = LOST_LINK;
                        end
                    end else if (look.poll_busy && look.poll_idx == 3'd1) begin
                        reply = (q < 80) ? 16'h0 : 16'($urandom_range(1, 65535));
                    end
                end
                q = $urandom_range(0, 9);
                if (op == OP_MODE) begin
                    if (q < 4) mode = SPEED_MODE;
                    else if (q < 8) mode = TORQUE_MODE;
                end
                if (op == OP_CMD) begin
                    if (q == 0) cmd = 16'h8000;
                    else if (q == 1) cmd = 16'h7FFF;
                    else if (q < 5) cmd = 16'(int'(look.cmd) + $urandom_range(0, 6) - 3);
                end
            end
            add_req(op, now, ($urandom_range(0, 6) != 0), reply, mode, cmd);
        end
    endtask

    // all eight registers, written back to back while the block is idle
    task automatic write_regs(input t_regs v);
        for (int k = 0; k < 8; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(k);
            i_cfg_data <= v[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        regs = v;
        settings_n++;
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_if.valid || ops_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_setting(input t_regs v, input int n);
        drain();
        repeat (4) @(negedge i_clk);
        write_regs(v);
        add_random(n);
    endtask

    initial begin
        #500000;
        $display("servo_drive_bringup_supervisor_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_if.valid         = 1'b0;
        in_if.op            = '0;
        in_if.now_ms        = '0;
        in_if.reply_ready   = 1'b0;
        in_if.reply_value   = '0;
        in_if.mode_value    = '0;
        in_if.command_value = '0;
        out_if.ready        = 1'b0;
        model = sup_reset();
        look  = sup_reset();
        regs  = setting(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd500, 16'd100, 16'd2);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through bring-up with distinct register addresses
        write_regs(setting(16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505,
                           16'h1234, 16'd100, 16'd2));
        // idle to init, poll too early to run
        add_req(OP_TICK, 32'd0, 1'b0, 16'h0, 8'h0, 16'h0);
        // status read requested, then link lost while still in init
        add_req(OP_TICK, 32'd200, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd400, 1'b1, LOST_LINK, 8'h0, 16'h0);
        // init retry after its timeout, then a reply that is not ready yet
        add_req(OP_TICK, 32'd5600, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd5800, 1'b0, 16'hABCD, 8'h0, 16'h0);
        // good status moves init to alarm check; alarm reset from there
        add_req(OP_TICK, 32'd6000, 1'b1, 16'h0003, 8'h0, 16'h0);
        add_req(OP_ALARM_RST, 32'd6050, 1'b0, 16'h0, 8'h0, 16'h0);
        // alarm clear writes inside the window, alarm read back as zero
        add_req(OP_TICK, 32'd6200, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd6400, 1'b1, 16'h0000, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd6700, 1'b0, 16'h0, 8'h0, 16'h0);
        // step of exactly the period: no poll
        add_req(OP_TICK, 32'd6800, 1'b1, 16'hFFFF, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd7000, 1'b1, 16'h5A5A, 8'h0, 16'h0);
        // most negative command, sent as 0x8000 in speed mode
        add_req(OP_CMD, 32'd7100, 1'b0, 16'h0, 8'h0, 16'h8000);
        add_req(OP_TICK, 32'd7200, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd7400, 1'b1, 16'hFFFF, 8'h0, 16'h0);
        // mode change while running stops the drive with four writes plus a poll
        add_req(OP_CMD, 32'd7450, 1'b1, 16'hFFFF, 8'hFF, 16'h7FFF);
        add_req(OP_MODE, 32'd7500, 1'b1, 16'hFFFF, TORQUE_MODE, 16'hFFFF);
        add_req(OP_TICK, 32'd7600, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd7800, 1'b1, 16'h1234, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd8000, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd8200, 1'b1, 16'h0000, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd8400, 1'b0, 16'h0, 8'h0, 16'h0);
        add_req(OP_TICK, 32'd8600, 1'b1, 16'hFFFF, 8'h0, 16'h0);
        // torque mode writes both torque registers
        add_req(OP_TICK, 32'd8800, 1'b0, 16'h0, 8'h0, 16'h0);
        // change inside the deadband is not resent
        add_req(OP_CMD, 32'd8900, 1'b0, 16'h0, 8'h0, 16'h7FFE);
        add_req(OP_TICK, 32'd9000, 1'b1, 16'h0005, 8'h0, 16'h0);

        // random traffic over several register settings, extremes included
        run_setting(setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'd100,
                            16'($urandom_range(0, 20))), 48);
        run_setting(setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'd0, 16'd0), 48);
        run_setting(setting(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                            16'hFFFF, 16'hFFFF), 48);
        // time stamps cross the 32-bit wrap in this setting
        look_now = 32'hFFFF_E000;
        run_setting(setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom_range(1, 2000)),
                            16'($urandom_range(0, 300))), 48);
        run_setting(setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)),
                            16'($urandom_range(0, 8))), 48);

        drain();
        repeat (20) @(negedge i_clk);
        $display("covered %0d requests and %0d results over %0d register settings",
                 sent_n, checked_n, settings_n);
        $display("machine states reached (bit per state code): %b", seen);
        if (errors == 0 && ops_due.size() == 0) begin
            $display("servo_drive_bringup_supervisor_unit: match");
        end else begin
            $display("servo_drive_bringup_supervisor_unit: mismatch");
        end
        $finish;
    end

endmodule
